// File: rtl/core/sjf_pkg.sv
`timescale 1ns / 1ps
package sjf_pkg;
	localparam int MaxJobs = 16;
	localparam int SlotW = $clog2(MaxJobs);
	localparam int CountW = $clog2(MaxJobs + 1);
	localparam logic [15:0] SliceReset = 16'd15;
	localparam logic [15:0] IoWaitReset = 16'd30;

	typedef enum logic [2:0] {
		OUT_ADDED = 3'd0,
		OUT_FULL = 3'd1,
		OUT_IDLE = 3'd2,
		OUT_DONE = 3'd3,
		OUT_BLOCKED = 3'd4,
		OUT_REQUEUED = 3'd5
	} outcome_t;

	typedef enum logic [0:0] {
		REG_SLICE = 1'b0,
		REG_IOWAIT = 1'b1
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ADD_FIND,
		ST_BINS_SCAN,
		ST_BINS_SHIFT,
		ST_WAKE_CHECK,
		ST_RINS_SCAN,
		ST_RINS_SHIFT,
		ST_RUN_PICK,
		ST_RUN_CALC,
		ST_RUN_MUL,
		ST_RUN_END,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		LIST_NONE,
		LIST_BLOCKED,
		LIST_READY
	} list_t;

	// controller to datapath
	typedef struct packed {
		logic load_item;
		logic add_find;
		logic add_store;
		logic bins_step;
		logic bins_put;
		logic wake_pop;
		logic rins_step;
		logic rins_put;
		logic run_pick;
		logic run_calc;
		logic run_mul;
		logic run_end;
		logic idle_end;
		logic full_end;
		logic emit;
	} sjf_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_step;
		logic slot_free;
		logic bins_here;
		logic rins_here;
		logic wake_due;
		logic ready_empty;
		logic run_split;
		logic run_zero;
		list_t next_list;
	} sjf_stat_t;
endpackage

// File: rtl/core/sjf_ctrl.sv
`timescale 1ns / 1ps
module sjf_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  sjf_pkg::sjf_stat_t  stat,
	output sjf_pkg::sjf_cmd_t   cmd
);
	sjf_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= sjf_pkg::ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sjf_pkg::ST_IDLE: begin
				if (start) state_d = sjf_pkg::ST_ADD_FIND;
			end
			sjf_pkg::ST_ADD_FIND: begin
				if (stat.is_step) state_d = sjf_pkg::ST_WAKE_CHECK;
				else if (stat.slot_free) state_d = sjf_pkg::ST_BINS_SCAN;
				else state_d = sjf_pkg::ST_DONE;
			end
			sjf_pkg::ST_BINS_SCAN: begin
				if (stat.bins_here) state_d = sjf_pkg::ST_BINS_SHIFT;
			end
			sjf_pkg::ST_BINS_SHIFT: state_d = sjf_pkg::ST_DONE;
			sjf_pkg::ST_WAKE_CHECK: begin
				if (stat.wake_due) state_d = sjf_pkg::ST_RINS_SCAN;
				else if (stat.ready_empty) state_d = sjf_pkg::ST_DONE;
				else state_d = sjf_pkg::ST_RUN_PICK;
			end
			sjf_pkg::ST_RINS_SCAN: begin
				if (stat.rins_here) state_d = sjf_pkg::ST_RINS_SHIFT;
			end
			sjf_pkg::ST_RINS_SHIFT: begin
				if (stat.next_list == sjf_pkg::LIST_NONE) state_d = sjf_pkg::ST_DONE;
				else state_d = sjf_pkg::ST_WAKE_CHECK;
			end
			sjf_pkg::ST_RUN_PICK: state_d = sjf_pkg::ST_RUN_CALC;
			sjf_pkg::ST_RUN_CALC: state_d = sjf_pkg::ST_RUN_MUL;
			sjf_pkg::ST_RUN_MUL: state_d = sjf_pkg::ST_RUN_END;
			sjf_pkg::ST_RUN_END: begin
				if (stat.run_zero) state_d = sjf_pkg::ST_DONE;
				else if (stat.run_split) state_d = sjf_pkg::ST_BINS_SCAN;
				else state_d = sjf_pkg::ST_RINS_SCAN;
			end
			sjf_pkg::ST_DONE: state_d = sjf_pkg::ST_IDLE;
			default: state_d = sjf_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		busy = (state_q != sjf_pkg::ST_IDLE);
		unique case (state_q)
			sjf_pkg::ST_IDLE: cmd.load_item = start;
			sjf_pkg::ST_ADD_FIND: begin
				cmd.add_find = 1'b1;
				cmd.add_store = !stat.is_step && stat.slot_free;
				cmd.full_end = !stat.is_step && !stat.slot_free;
			end
			sjf_pkg::ST_BINS_SCAN: cmd.bins_step = 1'b1;
			sjf_pkg::ST_BINS_SHIFT: cmd.bins_put = 1'b1;
			sjf_pkg::ST_WAKE_CHECK: begin
				cmd.wake_pop = stat.wake_due;
				cmd.idle_end = !stat.wake_due && stat.ready_empty;
			end
			sjf_pkg::ST_RINS_SCAN: cmd.rins_step = 1'b1;
			sjf_pkg::ST_RINS_SHIFT: cmd.rins_put = 1'b1;
			sjf_pkg::ST_RUN_PICK: cmd.run_pick = 1'b1;
			sjf_pkg::ST_RUN_CALC: cmd.run_calc = 1'b1;
			sjf_pkg::ST_RUN_MUL: cmd.run_mul = 1'b1;
			sjf_pkg::ST_RUN_END: cmd.run_end = 1'b1;
			sjf_pkg::ST_DONE: cmd.emit = 1'b1;
			default: cmd = '0;
		endcase
	end

	a_emit_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> busy) else $error("emit outside item");
	a_idle_after_emit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> !busy) else $error("no return to idle");
	a_load_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_item |=> busy) else $error("item not taken");
endmodule

// File: rtl/core/sjf_datapath.sv
`timescale 1ns / 1ps
module sjf_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  sjf_pkg::sjf_cmd_t   cmd,
	output sjf_pkg::sjf_stat_t  stat,
	input  logic                action,
	input  logic [7:0]          job_id,
	input  logic [31:0]         arrival_time,
	input  logic [15:0]         exec_time,
	input  logic [15:0]         io_ratio,
	input  logic [15:0]         io_chance,
	input  logic [15:0]         io_split,
	input  logic [15:0]         time_slice_q,
	input  logic [15:0]         io_wait_q,
	output logic                done,
	output logic [2:0]          outcome,
	output logic [7:0]          run_job,
	output logic [31:0]         run_start,
	output logic [15:0]         run_length,
	output logic [15:0]         remaining,
	output logic [31:0]         response_time,
	output logic [31:0]         turnaround_time
);
	localparam int N = sjf_pkg::MaxJobs;
	localparam int SW = sjf_pkg::SlotW;
	localparam int CW = sjf_pkg::CountW;

	// per-slot stores
	logic [7:0]  label_q [N];
	logic [31:0] arrival_q [N];
	logic [15:0] rem_q [N];
	logic [31:0] resp_q [N];
	logic [15:0] ratio_q [N];
	logic [31:0] wake_q [N];
	logic [N-1:0] started_q, in_use_q;
	logic [SW-1:0] rord_q [N];
	logic [SW-1:0] bord_q [N];
	logic [CW-1:0] rcnt_q, bcnt_q;
	logic [31:0] now_q;

	// captured item
	logic        act_q;
	logic [7:0]  id_q;
	logic [31:0] arr_q;
	logic [15:0] exec_q, ratio_in_q, chance_q, split_q;

	// working registers
	logic [SW-1:0] slot_q;
	logic [CW-1:0] pos_q;
	logic [15:0]   run_q, left_q;
	logic          split_q_en;
	logic [31:0]   prod_q;
	sjf_pkg::list_t next_q;

	// result registers
	logic        done_q;
	logic [2:0]  oc_q;
	logic [7:0]  job_q;
	logic [31:0] start_q, resp_out_q, turn_q;
	logic [15:0] len_q, remo_q;

	// lowest free slot
	logic [SW-1:0] free_slot;
	logic          any_free;
	always_comb begin
		free_slot = '0;
		any_free = 1'b0;
		for (int i = N - 1; i >= 0; i--) begin
			if (!in_use_q[i]) begin
				free_slot = SW'(i);
				any_free = 1'b1;
			end
		end
	end

	logic [SW-1:0] bhead, rhead, bcur, rcur;
	logic [15:0] slice_eff, run_base;
	assign bhead = bord_q[0];
	assign rhead = rord_q[0];
	assign bcur = bord_q[pos_q[SW-1:0]];
	assign rcur = rord_q[pos_q[SW-1:0]];
	assign slice_eff = (time_slice_q == 16'd0) ? 16'd1 : time_slice_q;
	assign run_base = (rem_q[slot_q] < slice_eff) ? rem_q[slot_q] : slice_eff;

	logic [15:0] new_rem;
	logic [15:0] io_len;
	logic [31:0] end_time;
	assign io_len = prod_q[31:16] + 16'd1;
	assign new_rem = left_q - (split_q_en ? io_len : run_q);
	assign end_time = now_q + {16'd0, split_q_en ? io_len : run_q};

	assign stat.is_step = act_q;
	assign stat.slot_free = any_free;
	assign stat.bins_here = (pos_q == bcnt_q) || (wake_q[bcur] > wake_q[slot_q]);
	assign stat.rins_here = (pos_q == rcnt_q) || (rem_q[rcur] > rem_q[slot_q]);
	assign stat.wake_due = (bcnt_q != '0) && (wake_q[bhead] <= now_q);
	assign stat.ready_empty = (rcnt_q == '0);
	assign stat.run_split = split_q_en;
	assign stat.run_zero = (new_rem == 16'd0);
	assign stat.next_list = next_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q <= '0;
			in_use_q <= '0;
			rcnt_q <= '0;
			bcnt_q <= '0;
			now_q <= '0;
			done_q <= 1'b0;
			next_q <= sjf_pkg::LIST_NONE;
		end else begin
			done_q <= cmd.emit;
			if (cmd.load_item) begin
				act_q <= action;
				id_q <= job_id;
				arr_q <= arrival_time;
				exec_q <= exec_time;
				ratio_in_q <= io_ratio;
				chance_q <= io_chance;
				split_q <= io_split;
				next_q <= sjf_pkg::LIST_NONE;
				resp_out_q <= '0;
				turn_q <= '0;
				len_q <= '0;
				remo_q <= '0;
			end
			if (cmd.full_end) begin
				oc_q <= sjf_pkg::OUT_FULL;
				job_q <= id_q;
				start_q <= '0;
			end
			if (cmd.add_store) begin
				slot_q <= free_slot;
				in_use_q[free_slot] <= 1'b1;
				started_q[free_slot] <= 1'b0;
				label_q[free_slot] <= id_q;
				arrival_q[free_slot] <= arr_q;
				rem_q[free_slot] <= exec_q;
				resp_q[free_slot] <= '0;
				ratio_q[free_slot] <= ratio_in_q;
				wake_q[free_slot] <= arr_q;
				pos_q <= '0;
				oc_q <= sjf_pkg::OUT_ADDED;
				job_q <= id_q;
				start_q <= '0;
			end
			// scan for insert position, ties go after
			if (cmd.bins_step && !stat.bins_here) pos_q <= pos_q + CW'(1);
			if (cmd.rins_step && !stat.rins_here) pos_q <= pos_q + CW'(1);
			if (cmd.bins_put) begin
				for (int i = N - 1; i > 0; i--)
					if (CW'(i) > pos_q && CW'(i) <= bcnt_q) bord_q[i] <= bord_q[i-1];
				bord_q[pos_q[SW-1:0]] <= slot_q;
				bcnt_q <= bcnt_q + CW'(1);
			end
			if (cmd.rins_put) begin
				for (int i = N - 1; i > 0; i--)
					if (CW'(i) > pos_q && CW'(i) <= rcnt_q) rord_q[i] <= rord_q[i-1];
				rord_q[pos_q[SW-1:0]] <= slot_q;
				rcnt_q <= rcnt_q + CW'(1);
				next_q <= sjf_pkg::LIST_NONE;
			end
			if (cmd.wake_pop) begin
				slot_q <= bhead;
				for (int i = 0; i < N - 1; i++) bord_q[i] <= bord_q[i+1];
				bcnt_q <= bcnt_q - CW'(1);
				pos_q <= '0;
				// after the wake sweep the controller returns to wake check
				next_q <= sjf_pkg::LIST_READY;
			end
			if (cmd.idle_end) begin
				oc_q <= sjf_pkg::OUT_IDLE;
				job_q <= '0;
				start_q <= now_q;
				now_q <= now_q + 32'd1;
			end
			if (cmd.run_pick) begin
				slot_q <= rhead;
				for (int i = 0; i < N - 1; i++) rord_q[i] <= rord_q[i+1];
				rcnt_q <= rcnt_q - CW'(1);
			end
			if (cmd.run_calc) begin
				left_q <= rem_q[slot_q];
				run_q <= run_base;
				split_q_en <= (run_base > 16'd1) && (chance_q < ratio_q[slot_q]);
				if (!started_q[slot_q]) begin
					resp_q[slot_q] <= now_q - arrival_q[slot_q];
					started_q[slot_q] <= 1'b1;
				end
			end
			if (cmd.run_mul) prod_q <= 32'(split_q) * 32'(run_q - 16'd1);
			if (cmd.run_end) begin
				rem_q[slot_q] <= new_rem;
				job_q <= label_q[slot_q];
				start_q <= now_q;
				len_q <= split_q_en ? io_len : run_q;
				remo_q <= new_rem;
				resp_out_q <= resp_q[slot_q];
				now_q <= end_time;
				pos_q <= '0;
				next_q <= sjf_pkg::LIST_NONE;
				if (new_rem == 16'd0) begin
					oc_q <= sjf_pkg::OUT_DONE;
					turn_q <= end_time - arrival_q[slot_q];
					in_use_q[slot_q] <= 1'b0;
					started_q[slot_q] <= 1'b0;
				end else if (split_q_en) begin
					oc_q <= sjf_pkg::OUT_BLOCKED;
					wake_q[slot_q] <= end_time + {16'd0, io_wait_q};
				end else begin
					oc_q <= sjf_pkg::OUT_REQUEUED;
				end
			end
		end
	end

	assign done = done_q;
	assign outcome = oc_q;
	assign run_job = job_q;
	assign run_start = start_q;
	assign run_length = len_q;
	assign remaining = remo_q;
	assign response_time = resp_out_q;
	assign turnaround_time = turn_q;

	a_counts_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(rcnt_q + bcnt_q) <= CW'(N)) else $error("list overflow");
	a_run_nonzero_done: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit && oc_q == sjf_pkg::OUT_BLOCKED |-> remo_q != 16'd0)
		else $error("blocked with no work left");
	a_pick_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.run_pick |-> rcnt_q != '0) else $error("pick from empty list");
endmodule

// File: rtl/core/sjf_timeslice_scheduler.sv
`timescale 1ns / 1ps
// shortest-job-first scheduler with time slice and i/o splits
// channels: command input (start/busy), one result per item on a strobe (done),
// and an apb-style port for time_slice (0x0) and io_wait (0x4)
// an item is taken when start is high and busy is low; busy stays high until
// the result strobe, and in the cycle of the strobe the next item can be taken
// from accept to the result strobe: an add finds a free slot, scans the
// blocked list one entry per cycle for its place (ties go after), inserts
// and finishes; a full table finishes after the slot search; an idle step
// checks for a due wake-up and finishes; a step that runs a job first moves
// each due job into the ready list by its own scan and insert, then picks
// the ready head, works out the run and the split, multiplies and ends the
// run, then scans and inserts the job into the ready or blocked list unless
// it is done
// done pulses for one cycle with the result valid; the receiver cannot stall
// reset clears the lists, slot use, started bits and the clock, and loads
// time_slice 15 and io_wait 30; per-slot stores hold no reset value
module sjf_timeslice_scheduler (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        action,
	input  logic [7:0]  job_id,
	input  logic [31:0] arrival_time,
	input  logic [15:0] exec_time,
	input  logic [15:0] io_ratio,
	input  logic [15:0] io_chance,
	input  logic [15:0] io_split,
	output logic        done,
	output logic [2:0]  outcome,
	output logic [7:0]  run_job,
	output logic [31:0] run_start,
	output logic [15:0] run_length,
	output logic [15:0] remaining,
	output logic [31:0] response_time,
	output logic [31:0] turnaround_time,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	sjf_pkg::sjf_cmd_t  cmd;
	sjf_pkg::sjf_stat_t stat;
	logic [15:0] slice_q, iowait_q;
	logic wr_en;

	// config registers at word-aligned byte addresses
	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slice_q <= sjf_pkg::SliceReset;
			iowait_q <= sjf_pkg::IoWaitReset;
		end else if (wr_en && paddr[1:0] == 2'b00 && paddr[2] == 1'b0) begin
			slice_q <= pwdata[15:0];
		end else if (wr_en && paddr[1:0] == 2'b00 && paddr[2] == 1'b1) begin
			iowait_q <= pwdata[15:0];
		end
	end
	always_comb begin
		prdata = '0;
		unique case (sjf_pkg::reg_idx_t'(paddr[2]))
			sjf_pkg::REG_SLICE: prdata = {16'd0, slice_q};
			sjf_pkg::REG_IOWAIT: prdata = {16'd0, iowait_q};
			default: prdata = '0;
		endcase
	end

	sjf_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.stat(stat), .cmd(cmd)
	);

	sjf_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.action(action), .job_id(job_id), .arrival_time(arrival_time),
		.exec_time(exec_time), .io_ratio(io_ratio), .io_chance(io_chance),
		.io_split(io_split), .time_slice_q(slice_q), .io_wait_q(iowait_q),
		.done(done), .outcome(outcome), .run_job(run_job), .run_start(run_start),
		.run_length(run_length), .remaining(remaining),
		.response_time(response_time), .turnaround_time(turnaround_time)
	);
endmodule

// File: tb/tb_sjf_timeslice_scheduler.sv
`timescale 1ns / 1ps
module tb_sjf_timeslice_scheduler;
	localparam int CycleLimit = 3000000;

	// one scheduler result as seen on the ports
	typedef struct packed {
		logic [2:0]  oc;
		logic [7:0]  job;
		logic [31:0] st;
		logic [15:0] len;
		logic [15:0] rem;
		logic [31:0] resp;
		logic [31:0] tat;
	} sched_result_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic        action;
	logic [7:0]  job_id;
	logic [31:0] arrival_time;
	logic [15:0] exec_time;
	logic [15:0] io_ratio;
	logic [15:0] io_chance;
	logic [15:0] io_split;
	logic        done;
	logic [2:0]  outcome;
	logic [7:0]  run_job;
	logic [31:0] run_start;
	logic [15:0] run_length;
	logic [15:0] remaining;
	logic [31:0] response_time;
	logic [31:0] turnaround_time;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	sjf_timeslice_scheduler i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.action(action), .job_id(job_id), .arrival_time(arrival_time),
		.exec_time(exec_time), .io_ratio(io_ratio), .io_chance(io_chance),
		.io_split(io_split), .done(done), .outcome(outcome), .run_job(run_job),
		.run_start(run_start), .run_length(run_length), .remaining(remaining),
		.response_time(response_time), .turnaround_time(turnaround_time),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// 4 ns clock
	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// shadow copy of the scheduler state
	logic [7:0]  sh_label [sjf_pkg::MaxJobs];
	logic [31:0] sh_arrival [sjf_pkg::MaxJobs];
	logic [15:0] sh_left [sjf_pkg::MaxJobs];
	logic        sh_started [sjf_pkg::MaxJobs];
	logic [31:0] sh_resp [sjf_pkg::MaxJobs];
	logic [15:0] sh_ratio [sjf_pkg::MaxJobs];
	logic [31:0] sh_wake [sjf_pkg::MaxJobs];
	logic        sh_used [sjf_pkg::MaxJobs];
	int          ready_q[$];
	int          blocked_q[$];
	logic [31:0] sched_clock;
	logic [15:0] cfg_slice;
	logic [15:0] cfg_iowait;

	sched_result_t pending_results[$];
	int  error_count;
	int  cycle_count;
	int  idle_pct;   // chance in percent that the sender idles before an item

	// sorted insertions: a new entry goes after its equals
	task automatic blocked_put(input int s);
		int pos;
		pos = 0;
		while (pos < blocked_q.size() && sh_wake[blocked_q[pos]] <= sh_wake[s])
			pos++;
		blocked_q.insert(pos, s);
	endtask

	task automatic ready_put(input int s);
		int pos;
		pos = 0;
		while (pos < ready_q.size() && sh_left[ready_q[pos]] <= sh_left[s])
			pos++;
		ready_q.insert(pos, s);
	endtask

	// works out the result of one accepted item and advances the shadow state
	task automatic schedule_item(input logic act, input logic [7:0] id,
			input logic [31:0] arr, input logic [15:0] ex, input logic [15:0] rat,
			input logic [15:0] ch, input logic [15:0] sp);
		sched_result_t r;
		int s;
		logic [31:0] slice, left, run, io, st;
		logic [63:0] prod;
		r = '0;
		if (act == 1'b0) begin
			r.job = id;
			s = -1;
			for (int k = sjf_pkg::MaxJobs - 1; k >= 0; k--)
				if (!sh_used[k]) s = k;
			if (s < 0) begin
				r.oc = sjf_pkg::OUT_FULL;
			end else begin
				r.oc = sjf_pkg::OUT_ADDED;
				sh_used[s] = 1'b1;
				sh_label[s] = id;
				sh_arrival[s] = arr;
				sh_left[s] = ex;
				sh_started[s] = 1'b0;
				sh_resp[s] = '0;
				sh_ratio[s] = rat;
				sh_wake[s] = arr;
				blocked_put(s);
			end
		end else begin
			while (blocked_q.size() > 0 && sh_wake[blocked_q[0]] <= sched_clock)
				ready_put(blocked_q.pop_front());
			if (ready_q.size() == 0) begin
				r.oc = sjf_pkg::OUT_IDLE;
				r.st = sched_clock;
				sched_clock = sched_clock + 1;
			end else begin
				s = ready_q.pop_front();
				slice = (cfg_slice != 0) ? cfg_slice : 32'd1;
				left = sh_left[s];
				run = (left < slice) ? left : slice;
				io = 0;
				st = sched_clock;
				if (!sh_started[s]) begin
					sh_resp[s] = st - sh_arrival[s];
					sh_started[s] = 1'b1;
				end
				if (run > 1 && ch < sh_ratio[s]) begin
					prod = 64'(sp) * 64'(run - 1);
					io = 32'(prod >> 16) + 1;
					run = io;
				end
				sh_left[s] = 16'(left - run);
				r.job = sh_label[s];
				r.st = st;
				r.len = run[15:0];
				r.rem = sh_left[s];
				r.resp = sh_resp[s];
				if (sh_left[s] == 0) begin
					r.oc = sjf_pkg::OUT_DONE;
					r.tat = st + run - sh_arrival[s];
					sh_used[s] = 1'b0;
					sh_started[s] = 1'b0;
				end else if (io != 0) begin
					r.oc = sjf_pkg::OUT_BLOCKED;
					sh_wake[s] = st + run + 32'(cfg_iowait);
					blocked_put(s);
				end else begin
					r.oc = sjf_pkg::OUT_REQUEUED;
					ready_put(s);
				end
				sched_clock = st + run;
			end
		end
		pending_results.push_back(r);
	endtask

	// offers one item after a random idle gap and waits until it is taken
	task automatic send_item(input logic act, input logic [7:0] id,
			input logic [31:0] arr, input logic [15:0] ex, input logic [15:0] rat,
			input logic [15:0] ch, input logic [15:0] sp);
		int gap;
		gap = 0;
		while (gap < 20 && $urandom_range(99) < idle_pct)
			gap++;
		@(negedge clk);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		action <= act;
		job_id <= id;
		arrival_time <= arr;
		exec_time <= ex;
		io_ratio <= rat;
		io_chance <= ch;
		io_split <= sp;
		forever begin
			@(posedge clk);
			if (!busy) break;
		end
		schedule_item(act, id, arr, ex, rat, ch, sp);
	endtask

	task automatic stop_sending();
		@(negedge clk);
		start <= 1'b0;
	endtask

	task automatic wait_drained();
		stop_sending();
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// two-phase register write, only while nothing is in flight
	task automatic write_reg(input sjf_pkg::reg_idx_t idx, input logic [15:0] val);
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {idx, 2'b00};
		pwdata <= {16'h0, val};
		@(negedge clk);
		penable <= 1'b1;
		forever begin
			@(posedge clk);
			if (pready) break;
		end
		if (idx == sjf_pkg::REG_SLICE)
			cfg_slice = val;
		else
			cfg_iowait = val;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic step_item();
		send_item(1'b1, '0, '0, '0, '0, 16'($urandom), 16'($urandom));
	endtask

	// directed: extremes of the fields, zero exec time, splits, full table, idle
	task automatic test_directed();
		send_item(1'b1, 8'h00, '0, '0, '0, '0, '0);              // idle on empty
		send_item(1'b0, 8'h00, '0, 16'd0, '0, '0, '0);           // zero exec time
		step_item();
		send_item(1'b0, 8'hff, '0, 16'hffff, 16'hffff, '0, '0);
		send_item(1'b1, 8'h00, '0, '0, '0, 16'h0000, 16'hffff);  // split
		send_item(1'b1, 8'h00, '0, '0, '0, 16'hffff, 16'h0000);  // idle while the split job waits
		send_item(1'b1, 8'h00, '0, '0, '0, 16'h0000, 16'h0000);  // idle again
		send_item(1'b0, 8'h5a, 32'hffff_ffff, 16'd3, '0, '0, '0); // wakes never
		for (int k = 0; k < 15; k++)                              // fills the table
			send_item(1'b0, 8'(k + 1), sched_clock, 16'(k + 1), 16'(k * 4000), '0, '0);
		for (int k = 0; k < 3; k++)
			step_item();
	endtask

	// random: mostly jobs that arrive soon and run briefly, some wild values
	task automatic test_random(input int count);
		int n;
		logic [31:0] arr;
		logic [15:0] ex, rat;
		int live;
		n = 0;
		while (n < count) begin
			live = 0;
			foreach (sh_used[k])
				if (sh_used[k]) live++;
			if ($urandom_range(99) < ((live < 8) ? 50 : 25)) begin
				case ($urandom_range(19))
					0: arr = $urandom;
					1, 2: arr = sched_clock - $urandom_range(200);
					default: arr = sched_clock + $urandom_range(60);
				endcase
				case ($urandom_range(19))
					0: ex = 16'($urandom);
					1, 2: ex = 16'($urandom_range(5));
					default: ex = 16'($urandom_range(40, 1));
				endcase
				case ($urandom_range(3))
					0: rat = '0;
					1: rat = 16'hffff;
					default: rat = 16'($urandom);
				endcase
				send_item(1'b0, 8'($urandom), arr, ex, rat,
					16'($urandom), 16'($urandom));
			end else begin
				step_item();
			end
			n++;
		end
	endtask

	// result checker: every strobe must match the oldest expectation
	always @(posedge clk) begin
		sched_result_t exp_r, got;
		if (arst_n && done) begin
			got = {outcome, run_job, run_start, run_length, remaining,
				response_time, turnaround_time};
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result %p", $time, got);
				error_count++;
			end else begin
				exp_r = pending_results.pop_front();
				if (got.oc !== exp_r.oc)
					$display("%0t: outcome exp %0d got %0d", $time, exp_r.oc, got.oc);
				if (got.job !== exp_r.job)
					$display("%0t: run_job exp %0d got %0d", $time, exp_r.job, got.job);
				if (got.st !== exp_r.st)
					$display("%0t: run_start exp %0d got %0d", $time, exp_r.st, got.st);
				if (got.len !== exp_r.len)
					$display("%0t: run_length exp %0d got %0d", $time, exp_r.len, got.len);
				if (got.rem !== exp_r.rem)
					$display("%0t: remaining exp %0d got %0d", $time, exp_r.rem, got.rem);
				if (got.resp !== exp_r.resp)
					$display("%0t: response exp %0d got %0d", $time, exp_r.resp, got.resp);
				if (got.tat !== exp_r.tat)
					$display("%0t: turnaround exp %0d got %0d", $time, exp_r.tat, got.tat);
				if (got !== exp_r)
					error_count++;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CycleLimit) begin
			$display("sjf_timeslice_scheduler verification failed");
			$finish;
		end
	end

	initial begin
		error_count = 0;
		cycle_count = 0;
		idle_pct = 0;
		arst_n = 1'b0;
		start = 1'b0;
		action = 1'b0;
		job_id = '0;
		arrival_time = '0;
		exec_time = '0;
		io_ratio = '0;
		io_chance = '0;
		io_split = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		foreach (sh_used[k]) begin
			sh_used[k] = 1'b0;
			sh_started[k] = 1'b0;
		end
		sched_clock = '0;
		cfg_slice = sjf_pkg::SliceReset;
		cfg_iowait = sjf_pkg::IoWaitReset;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		// reset settings, no idling
		test_directed();
		test_random(150);
		wait_drained();

		// sender pauses until everything has come back, then zero slice and wait, idling often
		write_reg(sjf_pkg::REG_SLICE, 16'd0);
		write_reg(sjf_pkg::REG_IOWAIT, 16'd0);
		idle_pct = 63;
		test_random(150);
		wait_drained();

		// widest slice and longest wait
		write_reg(sjf_pkg::REG_SLICE, 16'hffff);
		write_reg(sjf_pkg::REG_IOWAIT, 16'hffff);
		idle_pct = 6;
		test_random(150);
		wait_drained();

		// short slice, moderate wait, mixed idling
		write_reg(sjf_pkg::REG_SLICE, 16'd4);
		write_reg(sjf_pkg::REG_IOWAIT, 16'd10);
		idle_pct = 63;
		test_random(75);
		idle_pct = 0;
		test_random(75);
		wait_drained();
		repeat (400) @(posedge clk);

		if (error_count == 0 && pending_results.size() == 0) begin
			$display("sjf_timeslice_scheduler verification clean");
		end else begin
			$display("sjf_timeslice_scheduler verification failed");
		end
		$finish;
	end
endmodule
